// ===== src/rpn_pkg.sv =====
// Shared types and constants for the ray pick nearest node block.
package rpn_pkg;

  localparam int MUL_BITS = 32;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_BITS-1:0] a;
    logic signed [MUL_BITS-1:0] b;
  } rpn_mul_req_t;

endpackage

// ===== src/rpn_mul.sv =====
// Bit-serial signed 32x32 multiplier: one multiplier bit per cycle, shift and add.
module rpn_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rpn_pkg::rpn_mul_req_t                  req,
  output logic                                   done,
  output logic signed [2*rpn_pkg::MUL_BITS-1:0]  product
);
  import rpn_pkg::*;

  localparam int CNT_BITS = $clog2(MUL_BITS);

  logic [MUL_BITS-1:0] mcand;
  logic [MUL_BITS-1:0] hi;
  logic [MUL_BITS-1:0] lo;
  logic [CNT_BITS-1:0] cnt;
  logic                neg;
  logic                run;
  logic                fix;
  logic [MUL_BITS:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix && !req.start && !run;
      if (req.start) begin
        mcand <= req.a[MUL_BITS-1] ? (~req.a + 1'b1) : req.a;
        lo    <= req.b[MUL_BITS-1] ? (~req.b + 1'b1) : req.b;
        hi    <= '0;
        neg   <= req.a[MUL_BITS-1] ^ req.b[MUL_BITS-1];
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        hi  <= sum[MUL_BITS:1];
        lo  <= {sum[0], lo[MUL_BITS-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(MUL_BITS - 1)) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        // sign correction is its own step, after the last shift-add step
        product <= neg ? -$signed({hi, lo}) : $signed({hi, lo});
        fix     <= 1'b0;
      end
    end
  end

endmodule

// ===== src/ray_pick_nearest_node.sv =====
// Ray picking: nearest node to a ray line and nearest intersected node.
//
// Input stream s_*: one transaction per item. s_tuser is the opcode (0 loads
// the ray origin and direction and starts a query, 1 is a node). s_tlast
// marks the final item of the query; its result goes out on m_* as one
// transaction holding both picked ids and their found flags.
// The user must write offsets on cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this. A node item runs
// 13 products through one bit-serial multiplier (each: load, 32 shift-add
// steps, sign fix, handoff) plus its setup and update states; a node that
// is not ahead of the ray origin stops after 3 products. The multiplier
// takes one multiplier bit per cycle.
// s_tready is high only while no item is in progress; a result waiting in
// the output register does not block the next item, but a later result
// waits until m_tready takes the one ahead of it.
// Reset (rst, synchronous) clears offsets, the ray and the query.
module ray_pick_nearest_node #(
  parameter int ID_BITS    = 20,
  parameter int COORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_id[19:0], pos_x[51:20], pos_y[83:52], pos_z[115:84], dir_x[147:116],
  // dir_y[179:148], dir_z[211:180], node_radius[242:212], zero fill
  input  logic [247:0] s_tdata,
  // opcode[0]
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // closest_id[19:0], closest_found[20], hit_id[40:21], hit_found[41], zero fill
  output logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import rpn_pkg::*;

  localparam int C = COORD_BITS;
  localparam logic [19:0] ID_MASK =
    (ID_BITS >= 20) ? 20'hFFFFF : 20'((64'd1 << ID_BITS) - 64'd1);
  localparam logic signed [C+1:0] CMAX = (C+2)'((64'sd1 <<< (C-1)) - 64'sd1);
  localparam logic signed [C+1:0] CMIN = -CMAX - (C+2)'(1);
  localparam logic signed [65:0] S32MAX = 66'sh7FFFFFFF;
  localparam logic signed [65:0] S32MIN = -S32MAX - 66'sd1;

  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;

  localparam logic       OP_START = 1'b0;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_FRONT = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [2:0] PH_DOT  = 3'd0;
  localparam logic [2:0] PH_PROJ = 3'd1;
  localparam logic [2:0] PH_LINE = 3'd2;
  localparam logic [2:0] PH_ORG  = 3'd3;
  localparam logic [2:0] PH_RAD  = 3'd4;

  function automatic logic signed [31:0] sat_c(input logic signed [C+1:0] x);
    if (x > CMAX) return 32'(CMAX);
    if (x < CMIN) return 32'(CMIN);
    return 32'(x);
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [65:0] x);
    if (x > S32MAX) return 32'(S32MAX);
    if (x < S32MIN) return 32'(S32MIN);
    return 32'(x);
  endfunction

  logic [2:0]              state;
  logic [2:0]              phase;
  logic [1:0]              lane;

  logic signed [C-1:0]     off [3];
  logic signed [C-1:0]     org [3];
  logic signed [31:0]      dir [3];
  logic signed [C-1:0]     pos [3];
  logic [19:0]             in_id;
  logic [C-2:0]            rad;
  logic                    in_last;

  logic signed [31:0]      d [3];
  logic signed [31:0]      o [3];
  logic signed [31:0]      e [3];
  logic signed [31:0]      t;
  logic signed [65:0]      dot_sum;
  logic signed [65:0]      h;
  logic [63:0]             line_sq;
  logic [63:0]             org_sq;
  logic [63:0]             rad_sq;

  logic [63:0]             best_line;
  logic [63:0]             best_hit;
  logic [19:0]             best_line_id;
  logic [19:0]             best_hit_id;
  logic                    line_found;
  logic                    hit_seen;

  rpn_mul_req_t            req;
  logic                    mul_done;
  logic signed [63:0]      prod;

  rpn_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .done    (mul_done),
    .product (prod)
  );

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    req.start = (state == ST_MUL);
    req.a     = d[lane];
    req.b     = dir[lane];
    unique case (phase)
      PH_DOT: begin
        req.a = d[lane];
        req.b = dir[lane];
      end
      PH_PROJ: begin
        req.a = t;
        req.b = dir[lane];
      end
      PH_LINE: begin
        req.a = e[lane];
        req.b = e[lane];
      end
      PH_ORG: begin
        req.a = o[lane];
        req.b = o[lane];
      end
      PH_RAD: begin
        req.a = $signed(32'(rad));
        req.b = $signed(32'(rad));
      end
      default: begin
        req.a = d[lane];
        req.b = dir[lane];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_DOT;
      lane         <= '0;
      m_tvalid     <= 1'b0;
      best_line    <= '1;
      best_hit     <= '1;
      best_line_id <= '0;
      best_hit_id  <= '0;
      line_found   <= 1'b0;
      hit_seen     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        off[i] <= '0;
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else begin
      // a new result loaded in ST_DONE keeps the valid flag up
      if (m_tvalid && m_tready && !(state == ST_DONE && in_last)) m_tvalid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_OFF_X: off[0] <= cfg_data[C-1:0];
          REG_OFF_Y: off[1] <= cfg_data[C-1:0];
          REG_OFF_Z: off[2] <= cfg_data[C-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_last <= s_tlast;
            if (s_tuser == OP_START) begin
              org[0] <= s_tdata[20 +: C];
              org[1] <= s_tdata[52 +: C];
              org[2] <= s_tdata[84 +: C];
              dir[0] <= s_tdata[116 +: 32];
              dir[1] <= s_tdata[148 +: 32];
              dir[2] <= s_tdata[180 +: 32];
              best_line    <= '1;
              best_hit     <= '1;
              best_line_id <= '0;
              best_hit_id  <= '0;
              line_found   <= 1'b0;
              hit_seen     <= 1'b0;
              state        <= ST_DONE;
            end else begin
              in_id  <= s_tdata[19:0] & ID_MASK;
              pos[0] <= s_tdata[20 +: C];
              pos[1] <= s_tdata[52 +: C];
              pos[2] <= s_tdata[84 +: C];
              rad    <= s_tdata[212 +: (C-1)];
              state  <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            d[i] <= sat_c((C+2)'(pos[i]) + (C+2)'(off[i]) - (C+2)'(org[i]));
            o[i] <= sat_c((C+2)'(pos[i]) - (C+2)'(org[i]));
          end
          dot_sum <= '0;
          h       <= '0;
          line_sq <= '0;
          org_sq  <= '0;
          phase   <= PH_DOT;
          lane    <= '0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            lane <= (lane == 2'd2 || phase == PH_RAD) ? 2'd0 : lane + 2'd1;
            unique case (phase)
              PH_DOT: begin
                dot_sum <= dot_sum + 66'(prod);
                h       <= h + 66'(prod >>> 2);
                state   <= (lane == 2'd2) ? ST_FRONT : ST_MUL;
              end
              PH_PROJ: begin
                e[lane] <= sat_32(66'(35'(d[lane]) - 35'(prod >>> 30)));
                if (lane == 2'd2) phase <= PH_LINE;
                state <= ST_MUL;
              end
              PH_LINE: begin
                line_sq <= line_sq + $unsigned(prod);
                if (lane == 2'd2) phase <= PH_ORG;
                state <= ST_MUL;
              end
              PH_ORG: begin
                org_sq <= org_sq + $unsigned(prod);
                if (lane == 2'd2) phase <= PH_RAD;
                state <= ST_MUL;
              end
              PH_RAD: begin
                rad_sq <= $unsigned(prod);
                state  <= ST_UPD;
              end
              default: state <= ST_UPD;
            endcase
          end
        end
        ST_FRONT: begin
          // the exact dot product decides whether the node lies ahead
          if (dot_sum > 66'sd0) begin
            t     <= sat_32(h >>> 28);
            phase <= PH_PROJ;
            state <= ST_MUL;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_UPD: begin
          if (line_sq < best_line) begin
            best_line    <= line_sq;
            best_line_id <= in_id;
            line_found   <= 1'b1;
          end
          if (line_sq <= rad_sq && org_sq < best_hit) begin
            best_hit    <= org_sq;
            best_hit_id <= in_id;
            hit_seen    <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!in_last) begin
            state <= ST_IDLE;
          end else if (!m_tvalid || m_tready) begin
            m_tdata <= {6'd0, hit_seen, hit_seen ? best_hit_id : 20'd0,
                        line_found, line_found ? best_line_id : 20'd0};
            m_tvalid     <= 1'b1;
            best_line    <= '1;
            best_hit     <= '1;
            best_line_id <= '0;
            best_hit_id  <= '0;
            line_found   <= 1'b0;
            hit_seen     <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
